// ----- sv/dins_pkg.sv -----
// shared types, constants and helper functions of the id number scanner
package dins_pkg;

    localparam int DEFAULT_POS_WIDTH = 32;
    localparam int OUT_POS_W         = 32;
    localparam int DIGITS_W          = 34;
    localparam int OUT_DATA_W        = 104;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 8;

    localparam logic [7:0] CHAR_SPACE  = 8'd32;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_NINE   = 8'd57;
    localparam logic [7:0] SEP_A_RESET = 8'd45;
    localparam logic [7:0] SEP_B_RESET = 8'd32;

    localparam logic [CFG_INDEX_W-1:0] REG_MOD11_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR_A  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR_B  = 2'd2;

    // phase names tell which digit is awaited next
    typedef enum logic [3:0] {
        PH_DAY_HI  = 4'd0,
        PH_DAY_LO  = 4'd1,
        PH_MON_HI  = 4'd2,
        PH_MON_LO  = 4'd3,
        PH_YEAR_HI = 4'd4,
        PH_YEAR_LO = 4'd5,
        PH_SER0    = 4'd6,
        PH_SER1    = 4'd7,
        PH_SER2    = 4'd8,
        PH_SER3    = 4'd9
    } phase_t;

    typedef struct packed {
        logic       mod11_enable;
        logic [7:0] separator_a;
        logic [7:0] separator_b;
    } cfg_t;

    typedef struct packed {
        logic [DIGITS_W-1:0]  id_digits;
        logic [OUT_POS_W-1:0] end_pos;
        logic [OUT_POS_W-1:0] start_pos;
    } result_t;

    // weight of the digit taken in a given phase
    function automatic logic [2:0] digit_weight(input phase_t ph);
        logic [2:0] w;
        case (ph)
            PH_DAY_HI:  w = 3'd4;
            PH_DAY_LO:  w = 3'd3;
            PH_MON_HI:  w = 3'd2;
            PH_MON_LO:  w = 3'd7;
            PH_YEAR_HI: w = 3'd6;
            PH_YEAR_LO: w = 3'd5;
            PH_SER0:    w = 3'd4;
            PH_SER1:    w = 3'd3;
            PH_SER2:    w = 3'd2;
            PH_SER3:    w = 3'd1;
            default:    w = 3'd0;
        endcase
        return w;
    endfunction

    // reduce a value below 77 modulo 11
    function automatic logic [3:0] mod11(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        for (int i = 0; i < 6; i++)
        begin
            if (r >= 7'd11)
            begin
                r = r - 7'd11;
            end
        end
        return r[3:0];
    endfunction

endpackage

// ----- sv/dins_scan_core.sv -----
// per-byte scanning state machine with running digit value and check sum
module dins_scan_core #(
    parameter int POS_WIDTH = dins_pkg::DEFAULT_POS_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         char_in,
    input  logic               last_byte,
    input  dins_pkg::cfg_t     cfg,
    output logic               res_valid,
    output dins_pkg::result_t  res
);

    dins_pkg::phase_t phase_reg, phase_next;
    logic             prior_dig_reg, prior_dig_next;
    logic             gap_reg, gap_next;
    logic             feb29_reg, feb29_next;
    logic             pending_reg, pending_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [POS_WIDTH-1:0] start_reg, start_next;

    logic [3:0] d0_reg, d0_next;
    logic [3:0] d1_reg, d1_next;
    logic [3:0] d2_reg, d2_next;
    logic [3:0] d4_reg, d4_next;
    logic [3:0] d5_reg, d5_next;
    logic [dins_pkg::DIGITS_W-1:0] acc_reg, acc_next;
    logic [3:0] sum_reg, sum_next;
    logic       nz_reg, nz_next;

    logic       dig;
    logic [3:0] d;
    logic [7:0] d_byte;
    logic [6:0] prod;
    logic [3:0] sum_plus;
    logic [dins_pkg::DIGITS_W-1:0] acc10d;
    logic       feb, day31, long_month, leap4, year0, ser_ok;
    logic [POS_WIDTH-1:0] pos_m1;
    logic [63:0] start_wide, pos_wide, pos_m1_wide;

    always_comb
    begin
        dig        = (char_in >= dins_pkg::CHAR_ZERO) && (char_in <= dins_pkg::CHAR_NINE);
        d_byte     = char_in - dins_pkg::CHAR_ZERO;
        d          = dig ? d_byte[3:0] : 4'd0;
        prod       = 7'(d) * 7'(dins_pkg::digit_weight(phase_reg));
        sum_plus   = dins_pkg::mod11(7'(sum_reg) + prod);
        acc10d     = (acc_reg << 3) + (acc_reg << 1) + dins_pkg::DIGITS_W'(d);
        feb        = (d2_reg == 4'd0) && (d == 4'd2);
        day31      = (d0_reg == 4'd3) && (d1_reg == 4'd1);
        long_month = (d2_reg == 4'd0) ? (d inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8})
                                      : (d inside {4'd0, 4'd2});
        leap4      = d4_reg[0] ? (d5_reg inside {4'd2, 4'd6})
                               : (d5_reg inside {4'd0, 4'd4, 4'd8});
        year0      = (d4_reg == 4'd0) && (d5_reg == 4'd0);
        ser_ok     = (nz_reg || (d != 4'd0))
                     && (!cfg.mod11_enable || (sum_plus == 4'd0));
        pos_m1      = pos_reg - POS_WIDTH'(1);
        start_wide  = 64'(start_reg);
        pos_wide    = 64'(pos_reg);
        pos_m1_wide = 64'(pos_m1);

        phase_next     = phase_reg;
        prior_dig_next = prior_dig_reg;
        gap_next       = gap_reg;
        feb29_next     = feb29_reg;
        pending_next   = pending_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        d4_next        = d4_reg;
        d5_next        = d5_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        nz_next        = nz_reg;

        res_valid     = 1'b0;
        res.start_pos = start_wide[dins_pkg::OUT_POS_W-1:0];
        res.end_pos   = pos_m1_wide[dins_pkg::OUT_POS_W-1:0];
        res.id_digits = acc_reg;

        if (fire)
        begin
            // a finished match waits for a non-digit after it
            if (pending_reg)
            begin
                pending_next = 1'b0;
                if (!dig)
                begin
                    res_valid = 1'b1;
                end
            end

            case (phase_reg)
                dins_pkg::PH_DAY_HI:
                begin
                    if (!prior_dig_reg && dig && (d <= 4'd3))
                    begin
                        d0_next    = d;
                        start_next = pos_reg;
                        acc_next   = dins_pkg::DIGITS_W'(d);
                        sum_next   = dins_pkg::mod11(prod);
                        phase_next = dins_pkg::PH_DAY_LO;
                    end
                end
                dins_pkg::PH_DAY_LO:
                begin
                    if (dig && ((d0_reg == 4'd0) ? (d >= 4'd1)
                                : ((d0_reg == 4'd3) ? (d <= 4'd1) : 1'b1)))
                    begin
                        d1_next    = d;
                        acc_next   = acc10d;
                        sum_next   = sum_plus;
                        gap_next   = 1'b1;
                        phase_next = dins_pkg::PH_MON_HI;
                    end
                    else
                    begin
                        phase_next = dins_pkg::PH_DAY_HI;
                    end
                end
                dins_pkg::PH_MON_HI:
                begin
                    if ((char_in == dins_pkg::CHAR_SPACE) && gap_reg)
                    begin
                        gap_next = 1'b0;
                    end
                    else if (dig && (d <= 4'd1))
                    begin
                        d2_next    = d;
                        acc_next   = acc10d;
                        sum_next   = sum_plus;
                        phase_next = dins_pkg::PH_MON_LO;
                    end
                    else
                    begin
                        phase_next = dins_pkg::PH_DAY_HI;
                    end
                end
                dins_pkg::PH_MON_LO:
                begin
                    if (dig && ((d2_reg == 4'd0) ? (d >= 4'd1) : (d <= 4'd2)))
                    begin
                        acc_next   = acc10d;
                        sum_next   = sum_plus;
                        feb29_next = feb && (d0_reg == 4'd2) && (d1_reg == 4'd9);
                        if ((feb && (d0_reg == 4'd3)) || (!feb && day31 && !long_month))
                        begin
                            phase_next = dins_pkg::PH_DAY_HI;
                        end
                        else
                        begin
                            gap_next   = 1'b1;
                            phase_next = dins_pkg::PH_YEAR_HI;
                        end
                    end
                    else
                    begin
                        phase_next = dins_pkg::PH_DAY_HI;
                    end
                end
                dins_pkg::PH_YEAR_HI:
                begin
                    if ((char_in == dins_pkg::CHAR_SPACE) && gap_reg)
                    begin
                        gap_next = 1'b0;
                    end
                    else if (dig)
                    begin
                        d4_next    = d;
                        acc_next   = acc10d;
                        sum_next   = sum_plus;
                        phase_next = dins_pkg::PH_YEAR_LO;
                    end
                    else
                    begin
                        phase_next = dins_pkg::PH_DAY_HI;
                    end
                end
                dins_pkg::PH_YEAR_LO:
                begin
                    if (dig)
                    begin
                        d5_next    = d;
                        acc_next   = acc10d;
                        sum_next   = sum_plus;
                        gap_next   = 1'b1;
                        phase_next = dins_pkg::PH_SER0;
                    end
                    else
                    begin
                        phase_next = dins_pkg::PH_DAY_HI;
                    end
                end
                dins_pkg::PH_SER0:
                begin
                    if (gap_reg && ((char_in == cfg.separator_a)
                                    || (char_in == cfg.separator_b)))
                    begin
                        gap_next = 1'b0;
                    end
                    else if (dig)
                    begin
                        acc_next = acc10d;
                        sum_next = sum_plus;
                        nz_next  = (d != 4'd0);
                        // 29 february needs a leap year, century digit decides year 00
                        if (feb29_reg && (!leap4 || (year0 && (d < 4'd4))))
                        begin
                            phase_next = dins_pkg::PH_DAY_HI;
                        end
                        else
                        begin
                            phase_next = dins_pkg::PH_SER1;
                        end
                    end
                    else
                    begin
                        phase_next = dins_pkg::PH_DAY_HI;
                    end
                end
                dins_pkg::PH_SER1, dins_pkg::PH_SER2:
                begin
                    if (dig)
                    begin
                        acc_next   = acc10d;
                        sum_next   = sum_plus;
                        nz_next    = nz_reg || (d != 4'd0);
                        phase_next = (phase_reg == dins_pkg::PH_SER1) ? dins_pkg::PH_SER2
                                                                      : dins_pkg::PH_SER3;
                    end
                    else
                    begin
                        phase_next = dins_pkg::PH_DAY_HI;
                    end
                end
                dins_pkg::PH_SER3:
                begin
                    phase_next = dins_pkg::PH_DAY_HI;
                    if (dig && ser_ok)
                    begin
                        acc_next = acc10d;
                        if (last_byte)
                        begin
                            res_valid     = 1'b1;
                            res.end_pos   = pos_wide[dins_pkg::OUT_POS_W-1:0];
                            res.id_digits = acc10d;
                        end
                        else
                        begin
                            pending_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = dins_pkg::PH_DAY_HI;
                end
            endcase

            prior_dig_next = dig;
            pos_next       = pos_reg + POS_WIDTH'(1);

            if (last_byte)
            begin
                phase_next     = dins_pkg::PH_DAY_HI;
                prior_dig_next = 1'b0;
                gap_next       = 1'b0;
                feb29_next     = 1'b0;
                pending_next   = 1'b0;
                pos_next       = '0;
                start_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dins_pkg::PH_DAY_HI;
            prior_dig_reg <= 1'b0;
            gap_reg       <= 1'b0;
            feb29_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            pos_reg       <= '0;
            start_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            prior_dig_reg <= prior_dig_next;
            gap_reg       <= gap_next;
            feb29_reg     <= feb29_next;
            pending_reg   <= pending_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg  <= d0_next;
        d1_reg  <= d1_next;
        d2_reg  <= d2_next;
        d4_reg  <= d4_next;
        d5_reg  <= d5_next;
        acc_reg <= acc_next;
        sum_reg <= sum_next;
        nz_reg  <= nz_next;
    end

endmodule

// ----- sv/dins_out_reg.sv -----
// result register that parts the input side from the output handshake
module dins_out_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  dins_pkg::result_t             load_data,
    input  logic                          ready,
    output logic                          can_load,
    output logic                          valid,
    output logic [dins_pkg::OUT_DATA_W-1:0] data
);

    logic              valid_reg, valid_next;
    dins_pkg::result_t data_reg;

    assign can_load = !valid_reg || ready;
    assign valid    = valid_reg;
    assign data     = dins_pkg::OUT_DATA_W'(data_reg);

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ----- sv/danish_id_number_scanner.sv -----
// Scans a byte stream for ten-digit personal id numbers (DDMMYY-SSSS) and
// reports each match with its start position, end position and digits. The
// block takes one byte per clock while s_tready is high: every accepted word
// is handled by the scanning state machine, and a match lands in the result
// register in the cycle after the byte that completes it. A match is complete
// on the byte after its last digit (when that byte is a non-digit) or on its
// last digit itself when that byte carries tlast. s_tready is low only while
// the result register holds a word that the sink does not take in the same
// cycle. Positions count every byte of the text from zero, wrap at
// POS_WIDTH bits and restart after each tlast; the output carries their low
// 32 bits. Configuration writes go straight to the registers and should be
// made while no text is in flight.
module danish_id_number_scanner #(
    parameter int POS_WIDTH = dins_pkg::DEFAULT_POS_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] char_in
    input  logic                                s_tlast,   // last_byte
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] start_pos, [63:32] end_pos, [97:64] id_digits, rest zero
    output logic [dins_pkg::OUT_DATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [dins_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dins_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dins_pkg::cfg_t    cfg_reg;
    dins_pkg::result_t res;
    logic              res_valid;
    logic              fire;
    logic              can_load;

    // one byte enters whenever the result register has room
    assign s_tready = can_load;
    assign fire     = s_tvalid && s_tready;

    // configuration registers, writes outside the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mod11_enable <= 1'b1;
            cfg_reg.separator_a  <= dins_pkg::SEP_A_RESET;
            cfg_reg.separator_b  <= dins_pkg::SEP_B_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dins_pkg::REG_MOD11_ENABLE: cfg_reg.mod11_enable <= cfg_data[0];
                dins_pkg::REG_SEPARATOR_A:  cfg_reg.separator_a  <= cfg_data;
                dins_pkg::REG_SEPARATOR_B:  cfg_reg.separator_b  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // scanning state machine, one byte per accepted word
    dins_scan_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_in   (s_tdata),
        .last_byte (s_tlast),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register toward the sink
    dins_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .load_data (res),
        .ready     (m_tready),
        .can_load  (can_load),
        .valid     (m_tvalid),
        .data      (m_tdata)
    );

endmodule

// ----- sv/dins_checker.sv -----
// port-level checks of the id number scanner and their bind
module dins_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dins_pkg::OUT_DATA_W-1:0] m_tdata
);

    // a stalled result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    // input is open whenever the result register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // a result only follows an accepted byte
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result word without an accepted byte");

    // ten decimal digits never exceed 9999999999
    a_digits_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[97:64] <= 34'd9999999999))
        else $error("id digits out of range");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[103:98] == 6'd0))
        else $error("padding bits set in result word");

endmodule

bind danish_id_number_scanner dins_checker u_dins_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
